### hw/rtl/wmv_pkg.sv
// Shared types and constants for the weighted mean and variance block.
package wmv_pkg;

  localparam int unsigned CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam int unsigned DivCntW   = 5;
  localparam logic [DivCntW-1:0] MeanQBits = 5'd16;
  localparam logic [DivCntW-1:0] SqQBits   = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_WS,
    ST_MUL_SS,
    ST_MUL_WQ,
    ST_ACC,
    ST_DIV_MEAN,
    ST_WAIT_MEAN,
    ST_MUL_MM,
    ST_DIV_SQ,
    ST_WAIT_SQ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic               start;
    logic [31:0]        rem_init;
    logic [31:0]        low;
    logic [31:0]        den;
    logic [DivCntW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### hw/rtl/wmv_mul.sv
// Shared signed multiplier with registered product.
module wmv_mul (
  input  logic                clk_i,
  input  logic signed [17:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic signed [49:0]  p_o
);

  logic signed [49:0] p_q;
  logic signed [49:0] p_d;

  assign p_d = 50'(a_i * b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### hw/rtl/wmv_div.sv
// Restoring divider, one quotient bit per cycle.
module wmv_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wmv_pkg::div_req_t       req_i,
  output wmv_pkg::div_status_t    status_o,
  output logic [31:0]             quot_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [wmv_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]                 rem_q, rem_d;
  logic [31:0]                 low_q, low_d;
  logic [31:0]                 den_q, den_d;
  logic [31:0]                 quot_q, quot_d;
  logic [32:0]                 trial;
  logic [33:0]                 diff;
  logic                        ge;

  assign trial = {rem_q, low_q[31]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[33];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      rem_d  = req_i.rem_init;
      low_d  = req_i.low;
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[31:0] : trial[31:0];
      low_d  = {low_q[30:0], 1'b0};
      quot_d = {quot_q[30:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == wmv_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

### hw/rtl/weighted_mean_variance.sv
// Weighted running mean and variance, top level with sequencer and accumulators.
// The shared divider gives 16 quotient bits for the mean and 31 for the mean of
// squares; the shared multiplier forms the products. New requests are taken only
// in the idle state, after the last result is loaded; a request refused as full
// skips to the load. An output stall holds the sequencer in its last state.
// Reset: asynchronous, active low; clears all accumulators, count, mean and variance.
module weighted_mean_variance (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  sample_i,
  input  logic [15:0]         weight_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  mean_o,
  output logic [31:0]         variance_o,
  output logic [15:0]         sample_count_o,
  output logic                full_res_o
);

  wmv_pkg::state_e state_q, state_d;

  logic signed [15:0]              s_q, s_d;
  logic [15:0]                     w_q, w_d;
  logic                            full_q, full_d;
  logic [31:0]                     wt_q, wt_d;
  logic signed [47:0]              wv_q, wv_d;
  logic [63:0]                     wsq_q, wsq_d;
  logic [wmv_pkg::CountBits-1:0]   cnt_q, cnt_d;
  logic signed [16:0]              mean_q, mean_d;
  logic [30:0]                     mm_q, mm_d;
  logic [31:0]                     var_q, var_d;

  logic                            out_valid_q, out_valid_d;
  logic signed [15:0]              mean_out_q, mean_out_d;
  logic [31:0]                     var_out_q, var_out_d;
  logic [15:0]                     cnt_out_q, cnt_out_d;
  logic                            full_out_q, full_out_d;

  logic signed [17:0]              mul_a;
  logic signed [31:0]              mul_b;
  logic signed [49:0]              mul_p;

  wmv_pkg::div_req_t               div_req;
  wmv_pkg::div_status_t            div_st;
  logic [31:0]                     div_q;

  logic [47:0]                     wv_abs;
  logic [16:0]                     mean_mag;
  logic                            out_free;

  assign wv_abs   = wv_q[47] ? 48'(-wv_q) : wv_q;
  assign mean_mag = {1'b0, div_q[15:0]};
  assign out_free = ~out_valid_q | ~out_stall_i;

  wmv_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  wmv_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (div_req),
    .status_o (div_st),
    .quot_o   (div_q)
  );

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    w_d         = w_q;
    full_d      = full_q;
    wt_d        = wt_q;
    wv_d        = wv_q;
    wsq_d       = wsq_q;
    cnt_d       = cnt_q;
    mean_d      = mean_q;
    mm_d        = mm_q;
    var_d       = var_q;
    out_valid_d = out_valid_q & out_stall_i;
    mean_out_d  = mean_out_q;
    var_out_d   = var_out_q;
    cnt_out_d   = cnt_out_q;
    full_out_d  = full_out_q;
    mul_a       = {{2{s_q[15]}}, s_q};
    mul_b       = 32'(s_q);
    div_req     = '0;
    in_stall_o  = 1'b1;

    case (state_q)
      wmv_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          s_d    = sample_i;
          w_d    = (weight_i == 16'd0) ? 16'd1 : weight_i;
          full_d = (cnt_q == wmv_pkg::CountMax);
          state_d = full_d ? wmv_pkg::ST_LOAD : wmv_pkg::ST_MUL_WS;
        end
      end
      wmv_pkg::ST_MUL_WS: begin
        mul_a   = {2'b00, w_q};
        state_d = wmv_pkg::ST_MUL_SS;
      end
      wmv_pkg::ST_MUL_SS: begin
        wv_d    = wv_q + mul_p[47:0];
        state_d = wmv_pkg::ST_MUL_WQ;
      end
      wmv_pkg::ST_MUL_WQ: begin
        mul_a   = {2'b00, w_q};
        mul_b   = mul_p[31:0];
        wt_d    = wt_q + {16'd0, w_q};
        state_d = wmv_pkg::ST_ACC;
      end
      wmv_pkg::ST_ACC: begin
        wsq_d   = wsq_q + {16'd0, mul_p[47:0]};
        cnt_d   = cnt_q + 1'b1;
        state_d = wmv_pkg::ST_DIV_MEAN;
      end
      wmv_pkg::ST_DIV_MEAN: begin
        div_req.start    = 1'b1;
        div_req.rem_init = wv_abs[47:16];
        div_req.low      = {wv_abs[15:0], 16'd0};
        div_req.den      = wt_q;
        div_req.nbits    = wmv_pkg::MeanQBits;
        state_d          = wmv_pkg::ST_WAIT_MEAN;
      end
      wmv_pkg::ST_WAIT_MEAN: begin
        if (div_st.done) begin
          mean_d  = wv_q[47] ? 17'(-mean_mag) : mean_mag;
          state_d = wmv_pkg::ST_MUL_MM;
        end
      end
      wmv_pkg::ST_MUL_MM: begin
        mul_a   = {mean_q[16], mean_q};
        mul_b   = 32'(mean_q);
        state_d = wmv_pkg::ST_DIV_SQ;
      end
      wmv_pkg::ST_DIV_SQ: begin
        mm_d             = mul_p[30:0];
        div_req.start    = 1'b1;
        div_req.rem_init = wsq_q[62:31];
        div_req.low      = {wsq_q[30:0], 1'b0};
        div_req.den      = wt_q;
        div_req.nbits    = wmv_pkg::SqQBits;
        state_d          = wmv_pkg::ST_WAIT_SQ;
      end
      wmv_pkg::ST_WAIT_SQ: begin
        if (div_st.done) begin
          if (cnt_q > wmv_pkg::CountBits'(1) && div_q[30:0] > mm_q) begin
            var_d = {1'b0, div_q[30:0] - mm_q};
          end else begin
            var_d = '0;
          end
          state_d = wmv_pkg::ST_LOAD;
        end
      end
      wmv_pkg::ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          mean_out_d  = mean_q[15:0];
          var_out_d   = var_q;
          cnt_out_d   = 16'(cnt_q);
          full_out_d  = full_q;
          state_d     = wmv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wmv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmv_pkg::ST_IDLE;
      full_q      <= 1'b0;
      wt_q        <= '0;
      wv_q        <= '0;
      wsq_q       <= '0;
      cnt_q       <= '0;
      mean_q      <= '0;
      var_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      full_q      <= full_d;
      wt_q        <= wt_d;
      wv_q        <= wv_d;
      wsq_q       <= wsq_d;
      cnt_q       <= cnt_d;
      mean_q      <= mean_d;
      var_q       <= var_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    w_q        <= w_d;
    mm_q       <= mm_d;
    mean_out_q <= mean_out_d;
    var_out_q  <= var_out_d;
    cnt_out_q  <= cnt_out_d;
    full_out_q <= full_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign mean_o         = mean_out_q;
  assign variance_o     = var_out_q;
  assign sample_count_o = cnt_out_q;
  assign full_res_o     = full_out_q;

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !div_st.busy)
    else $error("divider busy while taking requests");

  a_full_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_res_o) |-> (sample_count_o == 16'(wmv_pkg::CountMax)))
    else $error("full reported below maximum count");

  a_var_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && variance_o != 32'd0) |-> (sample_count_o > 16'd1))
    else $error("variance nonzero with fewer than two samples");

  a_wait_has_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wmv_pkg::ST_WAIT_SQ && !div_st.done) |-> div_st.busy)
    else $error("waiting on an idle divider");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the weighted running mean and variance block.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 16_000_000;
  localparam int unsigned TailCycles = 120;

  typedef struct {
    logic signed [15:0] mean;
    logic [31:0]        variance;
    logic [15:0]        count;
    logic               full;
  } stats_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] sample;
  logic [15:0]        weight;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] mean;
  logic [31:0]        variance;
  logic [15:0]        sample_count;
  logic               full_res;

  logic [31:0]        weight_sum;
  longint             weighted_value_sum;
  logic [63:0]        weighted_square_sum;
  int unsigned        samples_taken;
  logic [31:0]        held_variance;

  stats_t             expected_stats[$];
  int unsigned        error_count;
  int unsigned        request_count;
  int unsigned        refused_count;
  int unsigned        result_count;
  int unsigned        cycle_count;
  int unsigned        gap_pct;
  int unsigned        stall_pct;

  weighted_mean_variance u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .weight_i       (weight),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .mean_o         (mean),
    .variance_o     (variance),
    .sample_count_o (sample_count),
    .full_res_o     (full_res)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic stats_t accumulate_sample(logic signed [15:0] s, logic [15:0] w_in);
    stats_t      r;
    logic [31:0] w;
    longint      sv;
    logic [63:0] sq;
    longint      m;
    logic [63:0] avg_sq;
    logic [63:0] m_sq;
    w = (w_in == 16'd0) ? 32'd1 : {16'd0, w_in};
    sv = s;
    r.full = (samples_taken >= wmv_pkg::CountMax);
    if (!r.full) begin
      sq = sv * sv;
      weight_sum += w;
      weighted_value_sum += longint'(w) * sv;
      weighted_square_sum += {32'd0, w} * sq;
      samples_taken++;
    end
    m = (weight_sum == 32'd0) ? 0 : weighted_value_sum / longint'(weight_sum);
    if (!r.full) begin
      if (samples_taken > 1) begin
        avg_sq = weighted_square_sum / {32'd0, weight_sum};
        m_sq = m * m;
        if (avg_sq <= m_sq) held_variance = 32'd0;
        else if (avg_sq - m_sq > 64'hFFFF_FFFF) held_variance = 32'hFFFF_FFFF;
        else held_variance = 32'(avg_sq - m_sq);
      end else begin
        held_variance = 32'd0;
      end
    end
    r.mean = 16'(m);
    r.variance = held_variance;
    r.count = 16'(samples_taken);
    return r;
  endfunction

  task automatic send_request(input logic signed [15:0] s, input logic [15:0] w);
    stats_t e;
    in_valid <= 1'b1;
    sample <= s;
    weight <= w;
    do @(posedge clk_i); while (in_stall);
    e = accumulate_sample(s, w);
    expected_stats.push_back(e);
    request_count++;
    if (e.full) refused_count++;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom_range(0, 1) ? -1 : 0);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_field_extremes();
    gap_pct = 0;
    stall_pct = 0;
    send_request(16'sd0, 16'd0);
    send_request(16'sd32767, 16'hFFFF);
    send_request(-16'sd32768, 16'hFFFF);
    send_request(-16'sd32768, 16'd0);
    send_request(16'sd32767, 16'd0);
    send_request(16'sd1, 16'd1);
    send_request(-16'sd1, 16'h0100);
    send_request(16'sd0, 16'hFFFF);
    send_request(16'sh5555, 16'hAAAA);
    send_request(-16'sh5556, 16'h5555);
    send_request(16'sd256, 16'h0100);
    send_request(16'sd256, 16'h0100);
    send_request(16'sd256, 16'h0100);
    send_request(-16'sd32768, 16'hFFFF);
    send_request(-16'sd32768, 16'hFFFF);
    send_request(16'sd32767, 16'h8000);
    send_request(-16'sd1, 16'd1);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        gap_pct = (i % 600 == 0) ? 0 : $urandom_range(10, 60);
        stall_pct = (i % 600 == 400) ? 0 : $urandom_range(10, 60);
      end
      send_request(pick_sample(), pick_weight());
    end
  endtask

  task automatic test_drain_pause();
    gap_pct = 30;
    stall_pct = 30;
    repeat (20) send_request(pick_sample(), pick_weight());
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (20) send_request(pick_sample(), pick_weight());
  endtask

  task automatic test_back_to_back_tail();
    gap_pct = 0;
    stall_pct = 0;
    send_request(-16'sd32768, 16'd0);
    send_request(16'sd32767, 16'hFFFF);
    repeat (30) send_request(pick_sample(), pick_weight());
    in_valid <= 1'b0;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct / 4) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      result_count++;
      if (expected_stats.size() == 0) begin
        $error("result with no request outstanding: mean %0d count %0d", mean, sample_count);
        error_count++;
      end else begin
        stats_t e;
        e = expected_stats.pop_front();
        if (mean !== e.mean) begin
          $error("mean: expected %0d, got %0d", e.mean, mean);
          error_count++;
        end
        if (variance !== e.variance) begin
          $error("variance: expected %0d, got %0d", e.variance, variance);
          error_count++;
        end
        if (sample_count !== e.count) begin
          $error("sample_count: expected %0d, got %0d", e.count, sample_count);
          error_count++;
        end
        if (full_res !== e.full) begin
          $error("full_res: expected %0b, got %0b", e.full, full_res);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_stats.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    sample = '0;
    weight = '0;
    gap_pct = 0;
    stall_pct = 0;
    error_count = 0;
    request_count = 0;
    refused_count = 0;
    result_count = 0;
    cycle_count = 0;
    weight_sum = '0;
    weighted_value_sum = 0;
    weighted_square_sum = '0;
    samples_taken = 0;
    held_variance = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_random_traffic(1700);
    test_drain_pause();
    test_back_to_back_tail();

    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_stats.size() != 0) begin
      $error("%0d results never arrived", expected_stats.size());
      error_count++;
    end

    $display("%0d requests sent, %0d results checked, %0d refused as full",
             request_count, result_count, refused_count);
    $display("covered zero and extreme weights, extreme samples, stall bursts and a full drain");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
